// ----- src/content_defined_chunker_defines.svh -----
// Assertion helpers used by the chunker source.
`ifndef CONTENT_DEFINED_CHUNKER_DEFINES_SVH
`define CONTENT_DEFINED_CHUNKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cdc_pkg.sv -----
`timescale 1ns / 1ps

package cdc_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int WIN_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W = WIN_AW + 1;
    localparam int WLEN_W = 11;
    localparam int WEFF_W = (WIN_AW + 1 > WLEN_W) ? WIN_AW + 1 : WLEN_W;
    localparam int MOD_W = 56;
    localparam int DIV_W = 64;
    localparam int CNT_W = (WEFF_W + 3 > 7) ? WEFF_W + 3 : 7;

    localparam logic [MOD_W-1:0] DEFAULT_MOD = 56'h3DA3358B4DC173;
    localparam logic [31:0] RST_TARGET = 32'd1024;
    localparam logic [24:0] RST_MIN = 25'd512;
    localparam logic [24:0] RST_MAX = 25'd4096;
    localparam logic [WLEN_W-1:0] RST_WLEN = 11'd48;
    localparam int RST_WEFF = (48 > WINDOW_MAX) ? WINDOW_MAX : 48;
    localparam logic [CNT_W-1:0] RST_PCNT = CNT_W'(8 * (RST_WEFF - 1));

    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_EOS = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 56;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WLEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HMOD = 3'd4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [47:0] end_offset;
        logic [24:0] chunk_length;
    } t_out_item;

    // One restoring step: shift a dividend bit into the remainder and reduce once.
    function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] rem,
                                                  input logic din,
                                                  input logic [MOD_W-1:0] modulus);
        logic [MOD_W:0] t;
        logic [MOD_W:0] m;
        t = {rem, din};
        m = {1'b0, modulus};
        if (t >= m) begin
            t = t - m;
        end
        return t[MOD_W-1:0];
    endfunction

endpackage

// ----- src/cdc_ram.sv -----
`timescale 1ns / 1ps

module cdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/content_defined_chunker.sv -----
// A data byte holds the input while it is processed, longer when the boundary test runs and when it
// emits; full-width reductions after a modulus change lengthen this further.
// An emitting request also waits while an earlier chunk sits in a stalled output register.
// The processing waits come from one shared bit-serial remainder unit that does every reduction.
// End of stream goes to the emit state only when a chunk is open; restart rebuilds the power term.
// Reset is synchronous; afterwards the power term is rebuilt before input is taken.
`timescale 1ns / 1ps
`include "content_defined_chunker_defines.svh"

module content_defined_chunker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cdc_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cdc_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cdc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cdc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import cdc_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_HEAD  = 10'b0000000100,
        ST_SUB   = 10'b0000001000,
        ST_HLD   = 10'b0000010000,
        ST_HASH  = 10'b0000100000,
        ST_CHECK = 10'b0001000000,
        ST_TEST  = 10'b0010000000,
        ST_DONE  = 10'b0100000000,
        ST_POWER = 10'b1000000000
    } t_state;

    t_state              r_st, n_st;
    logic [31:0]         r_target, n_target;
    logic [24:0]         r_min, n_min;
    logic [24:0]         r_max, n_max;
    logic [WLEN_W-1:0]   r_wlen, n_wlen;
    logic [MOD_W-1:0]    r_hmod, n_hmod;
    logic [WIN_AW-1:0]   r_widx, n_widx;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [MOD_W-1:0]    r_hash, n_hash;
    logic [MOD_W-1:0]    r_power, n_power;
    logic [47:0]         r_offset, n_offset;
    logic [24:0]         r_count, n_count;
    logic [7:0]          r_byte, n_byte;
    logic                r_old_ok, n_old_ok;
    logic [MOD_W-1:0]    r_mod, n_mod;
    logic [MOD_W-1:0]    r_rem, n_rem;
    logic [DIV_W-1:0]    r_div, n_div;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item, n_out_item;

    logic                w_in_acc;
    logic                w_ram_re;
    logic                w_ram_we;
    logic [7:0]          w_ram_rdata;
    logic [MOD_W-1:0]    w_eff_mod;
    logic [WEFF_W-1:0]   w_wlen_x;
    logic [WEFF_W-1:0]   w_eff_win;
    logic [CNT_W-1:0]    w_pcnt;
    logic [WEFF_W-1:0]   w_idx_next;
    logic [WIN_AW-1:0]   w_widx_new;
    logic [FILL_W-1:0]   w_idx_fill;
    logic [7:0]          w_old;
    logic [DIV_W-1:0]    w_prod;
    logic                w_step_bit;
    logic [MOD_W-1:0]    w_step;
    logic [MOD_W:0]      w_hsub;
    logic [24:0]         w_count_new;
    logic [31:0]         w_target_m1;

    cdc_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_MAX)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_widx),
        .i_wdata (r_byte),
        .i_re    (w_ram_re),
        .i_raddr (r_widx),
        .o_rdata (w_ram_rdata)
    );

    assign o_in_stall  = (r_st != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_in_acc = i_in_valid && (r_st == ST_IDLE);
    assign w_ram_re = w_in_acc && (i_in_item.opcode == OP_DATA);
    assign w_ram_we = (r_st == ST_MUL);

    assign w_eff_mod = (r_hmod == '0) ? DEFAULT_MOD : r_hmod;
    assign w_wlen_x  = WEFF_W'(r_wlen);
    assign w_eff_win = (r_wlen == '0) ? WEFF_W'(1) :
                       ((w_wlen_x > WEFF_W'(WINDOW_MAX)) ? WEFF_W'(WINDOW_MAX) : w_wlen_x);
    assign w_pcnt    = CNT_W'({w_eff_win - WEFF_W'(1), 3'b000});

    assign w_idx_next = WEFF_W'(r_widx) + WEFF_W'(1);
    assign w_widx_new = (w_idx_next >= w_eff_win) ? '0 : w_idx_next[WIN_AW-1:0];
    assign w_idx_fill = FILL_W'(r_widx) + FILL_W'(1);

    assign w_old  = r_old_ok ? w_ram_rdata : 8'd0;
    assign w_prod = {56'd0, w_old} * {8'd0, r_power};

    assign w_step_bit = (r_st == ST_POWER) ? 1'b0 : r_div[DIV_W-1];
    assign w_step     = mod_step(r_rem, w_step_bit, r_mod);

    assign w_hsub = (r_hash >= r_rem) ? ({1'b0, r_hash} - {1'b0, r_rem}) :
                    ({1'b0, r_hash} + {1'b0, r_mod} - {1'b0, r_rem});

    assign w_count_new = r_count + 25'd1;
    assign w_target_m1 = r_target - 32'd1;

    always_comb begin
        n_st        = r_st;
        n_target    = r_target;
        n_min       = r_min;
        n_max       = r_max;
        n_wlen      = r_wlen;
        n_hmod      = r_hmod;
        n_widx      = r_widx;
        n_fill      = r_fill;
        n_hash      = r_hash;
        n_power     = r_power;
        n_offset    = r_offset;
        n_count     = r_count;
        n_byte      = r_byte;
        n_old_ok    = r_old_ok;
        n_mod       = r_mod;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET: n_target = i_cfg_data[31:0];
                CFG_MIN:    n_min    = i_cfg_data[24:0];
                CFG_MAX:    n_max    = i_cfg_data[24:0];
                CFG_WLEN:   n_wlen   = i_cfg_data[WLEN_W-1:0];
                CFG_HMOD:   n_hmod   = i_cfg_data[MOD_W-1:0];
                default:    n_target = r_target;
            endcase
        end

        unique case (r_st)
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_in_item.opcode)
                        OP_DATA: begin
                            n_byte   = i_in_item.data_byte;
                            n_old_ok = (FILL_W'(r_widx) < r_fill);
                            n_mod    = w_eff_mod;
                            n_st     = ST_MUL;
                        end
                        OP_EOS: begin
                            if (r_count != '0) begin
                                n_st = ST_DONE;
                            end
                        end
                        OP_RESTART: begin
                            n_widx   = '0;
                            n_fill   = '0;
                            n_hash   = '0;
                            n_offset = '0;
                            n_count  = '0;
                            n_mod    = w_eff_mod;
                            n_cnt    = w_pcnt;
                            if ((w_eff_mod == MOD_W'(1)) && (w_pcnt != '0)) begin
                                n_rem = '0;
                            end else begin
                                n_rem = MOD_W'(1);
                            end
                            n_st = ST_POWER;
                        end
                        default: n_st = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                n_widx = w_widx_new;
                if (w_idx_fill > r_fill) begin
                    n_fill = w_idx_fill;
                end
                if (r_power < r_mod) begin
                    n_rem = w_prod[DIV_W-1:8];
                    n_div = {w_prod[7:0], 56'd0};
                    n_cnt = CNT_W'(8);
                end else begin
                    n_rem = '0;
                    n_div = w_prod;
                    n_cnt = CNT_W'(DIV_W);
                end
                n_st = ST_HEAD;
            end
            ST_HEAD: begin
                n_rem = w_step;
                n_div = {r_div[DIV_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_st = ST_SUB;
                end
            end
            ST_SUB: begin
                n_div = {w_hsub[MOD_W-1:0], r_byte};
                n_st  = ST_HLD;
            end
            ST_HLD: begin
                if (r_div[DIV_W-1:8] < r_mod) begin
                    n_rem = r_div[DIV_W-1:8];
                    n_div = {r_div[7:0], 56'd0};
                    n_cnt = CNT_W'(8);
                end else begin
                    n_rem = '0;
                    n_cnt = CNT_W'(DIV_W);
                end
                n_st = ST_HASH;
            end
            ST_HASH: begin
                n_rem = w_step;
                n_div = {r_div[DIV_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_st = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_hash   = r_rem;
                n_offset = r_offset + 48'd1;
                n_count  = w_count_new;
                priority if (w_count_new < r_min) begin
                    n_st = ST_IDLE;
                end else if (w_count_new >= r_max) begin
                    n_st = ST_DONE;
                end else if (r_target != '0) begin
                    n_mod = {24'd0, r_target};
                    n_rem = '0;
                    n_div = {r_rem, 8'd0};
                    n_cnt = CNT_W'(MOD_W);
                    n_st  = ST_TEST;
                end else begin
                    n_st = ST_IDLE;
                end
            end
            ST_TEST: begin
                n_rem = w_step;
                n_div = {r_div[DIV_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    if (w_step == {24'd0, w_target_m1}) begin
                        n_st = ST_DONE;
                    end else begin
                        n_st = ST_IDLE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_item.end_offset   = r_offset;
                    n_out_item.chunk_length = r_count;
                    n_out_valid = 1'b1;
                    n_count     = '0;
                    n_st        = ST_IDLE;
                end
            end
            ST_POWER: begin
                if (r_cnt == '0) begin
                    n_power = r_rem;
                    n_st    = ST_IDLE;
                end else begin
                    n_rem = w_step;
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_POWER;
            r_target    <= RST_TARGET;
            r_min       <= RST_MIN;
            r_max       <= RST_MAX;
            r_wlen      <= RST_WLEN;
            r_hmod      <= DEFAULT_MOD;
            r_widx      <= '0;
            r_fill      <= '0;
            r_hash      <= '0;
            r_offset    <= '0;
            r_count     <= '0;
            r_mod       <= DEFAULT_MOD;
            r_rem       <= MOD_W'(1);
            r_cnt       <= RST_PCNT;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_target    <= n_target;
            r_min       <= n_min;
            r_max       <= n_max;
            r_wlen      <= n_wlen;
            r_hmod      <= n_hmod;
            r_widx      <= n_widx;
            r_fill      <= n_fill;
            r_hash      <= n_hash;
            r_offset    <= n_offset;
            r_count     <= n_count;
            r_mod       <= n_mod;
            r_rem       <= n_rem;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_power    <= n_power;
        r_byte     <= n_byte;
        r_old_ok   <= n_old_ok;
        r_div      <= n_div;
        r_out_item <= n_out_item;
    end

    `CDC_ASSERT_NOW(a_rem_in_range, i_clk, i_rst_n, (r_st == ST_HEAD) || (r_st == ST_HASH) || (r_st == ST_TEST), r_rem < r_mod, "Remainder is not below the modulus.")
    `CDC_ASSERT_NOW(a_index_within_fill, i_clk, i_rst_n, 1'b1, FILL_W'(r_widx) <= r_fill, "Window index is past the filled region.")
    `CDC_ASSERT_NEXT(a_done_emits, i_clk, i_rst_n, (r_st == ST_DONE) && !(r_out_valid && i_out_stall), o_out_valid && (r_st == ST_IDLE), "A finished chunk did not reach the output register.")

endmodule

// ----- bench/content_defined_chunker_tb.sv -----
`timescale 1ns / 1ps

module content_defined_chunker_tb;
    import cdc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned BURST_MAX = 14;
    localparam int unsigned REPORT_MAX = 20;
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned ITEMS_PER_PHASE = 133;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_reg_write;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [31:0] set_target;
    logic [24:0] set_min;
    logic [24:0] set_max;
    logic [10:0] set_wlen;
    logic [55:0] set_hmod;

    logic [7:0]  recent_bytes [0:WINDOW_MAX-1];
    int unsigned slot;
    int unsigned weight_span;
    logic [55:0] fingerprint;
    logic [55:0] drop_weight;
    logic [47:0] bytes_seen;
    logic [24:0] open_len;

    t_out_item   expected_boundaries [$];
    t_in_item    pending_requests [$];
    t_reg_write  pending_writes [$];
    t_out_item   due;

    int unsigned send_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned requests_sent = 0;
    int unsigned boundaries_checked = 0;
    int unsigned phases_run = 0;
    int unsigned failures = 0;

    content_defined_chunker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] active_modulus();
        return (set_hmod == '0) ? {8'd0, DEFAULT_MOD} : {8'd0, set_hmod};
    endfunction

    function automatic int unsigned active_window();
        if (set_wlen == '0) return 1;
        if (set_wlen > WINDOW_MAX) return WINDOW_MAX;
        return 32'(set_wlen);
    endfunction

    // The weight of the byte that leaves the window is 256 to the power of window - 1, modulo the modulus.
    task automatic restart_stream();
        logic [63:0] m;
        logic [63:0] w;
        int i;
        m = active_modulus();
        for (i = 0; i < WINDOW_MAX; i++) recent_bytes[i] = 8'd0;
        slot = 0;
        fingerprint = '0;
        bytes_seen = '0;
        open_len = '0;
        weight_span = active_window();
        w = 64'd1;
        for (i = 1; i < weight_span; i++) w = (w << 8) % m;
        drop_weight = w[55:0];
    endtask

    task automatic cut_chunk();
        t_out_item c;
        c.end_offset = bytes_seen;
        c.chunk_length = open_len;
        expected_boundaries = {expected_boundaries, c};
        open_len = '0;
    endtask

    task automatic predict_boundary(input t_in_item req);
        logic [63:0] m;
        logic [63:0] head;
        logic [63:0] h;
        logic [7:0]  old;
        int unsigned idx;
        case (req.opcode)
            OP_RESTART: begin
                restart_stream();
            end
            OP_EOS: begin
                if (open_len != '0) cut_chunk();
            end
            OP_DATA: begin
                m = active_modulus();
                idx = (slot < WINDOW_MAX) ? slot : 0;
                old = recent_bytes[idx];
                recent_bytes[idx] = req.data_byte;
                slot = (idx + 1 >= active_window()) ? 0 : idx + 1;
                h = {8'd0, fingerprint};
                head = ({56'd0, old} * {8'd0, drop_weight}) % m;
                h = (h >= head) ? h - head : h + m - head;
                h = ({h[55:0], 8'd0} | {56'd0, req.data_byte}) % m;
                fingerprint = h[55:0];
                bytes_seen = bytes_seen + 48'd1;
                open_len = open_len + 25'd1;
                if (open_len >= set_min) begin
                    if (open_len >= set_max) begin
                        cut_chunk();
                    end else if (set_target != '0 &&
                                 ({8'd0, fingerprint} % {32'd0, set_target}) ==
                                 {32'd0, set_target - 32'd1}) begin
                        cut_chunk();
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (failures < REPORT_MAX) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
        failures++;
    endtask

    task automatic add_request(input logic [1:0] op, input logic [7:0] b);
        t_in_item r;
        r.opcode = op;
        r.data_byte = b;
        pending_requests = {pending_requests, r};
    endtask

    task automatic write_all(input logic [31:0] t, input logic [24:0] mn, input logic [24:0] mx,
                             input logic [10:0] wl, input logic [55:0] hm);
        t_reg_write w;
        w.index = CFG_TARGET; w.value = {24'd0, t};  pending_writes = {pending_writes, w};
        w.index = CFG_MIN;    w.value = {31'd0, mn}; pending_writes = {pending_writes, w};
        w.index = CFG_MAX;    w.value = {31'd0, mx}; pending_writes = {pending_writes, w};
        w.index = CFG_WLEN;   w.value = {45'd0, wl}; pending_writes = {pending_writes, w};
        w.index = CFG_HMOD;   w.value = hm;          pending_writes = {pending_writes, w};
        while (pending_writes.size() != 0 || i_cfg_valid) @(posedge i_clk);
        phases_run++;
    endtask

    // Once nothing is outstanding, allow for a request that produces no boundary,
    // such as a restart rebuilding the weight.
    task automatic drain();
        while (pending_requests.size() != 0 || i_in_valid || expected_boundaries.size() != 0)
            @(posedge i_clk);
        repeat (8 * weight_span + 400) @(posedge i_clk);
    endtask

    task automatic random_settings();
        logic [31:0] t;
        logic [24:0] mn;
        logic [24:0] mx;
        logic [10:0] wl;
        logic [55:0] hm;
        logic [63:0] r64;
        case ($urandom_range(0, 9))
            0: t = '0;
            1: t = 32'hFFFF_FFFF;
            2: t = 32'd1;
            default: t = $urandom_range(2, 48);
        endcase
        case ($urandom_range(0, 9))
            0: mn = '0;
            1: mn = 25'd16777216;
            2: mn = 25'd1;
            default: mn = 25'($urandom_range(1, 24));
        endcase
        case ($urandom_range(0, 7))
            0: mx = '0;
            1: mx = 25'd16777216;
            2: mx = (mn > 1) ? 25'($urandom_range(1, 32'(mn) - 1)) : '0;
            default: mx = mn + 25'($urandom_range(0, 60));
        endcase
        case ($urandom_range(0, 11))
            0: wl = 11'd1024;
            1: wl = 11'd1;
            2: wl = '0;
            3: wl = 11'd2047;
            default: wl = 11'($urandom_range(2, 64));
        endcase
        r64 = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: hm = '0;
            1: hm = {56{1'b1}};
            2: hm = 56'd2;
            3: hm = 56'($urandom_range(1, 5000));
            default: hm = r64[55:0];
        endcase
        write_all(t, mn, mx, wl, hm);
    endtask

    // Restart, then mostly data and end of stream; later restarts only in short windows.
    task automatic random_traffic(input int unsigned count);
        int unsigned made;
        int unsigned r;
        logic [7:0] b;
        made = 1;
        b = 8'($urandom);
        add_request(OP_RESTART, b);
        while (made < count) begin
            r = $urandom_range(0, 99);
            b = 8'($urandom);
            if (r < 86) begin
                add_request(OP_DATA, b);
                made++;
            end else if (r < 94) begin
                add_request(OP_EOS, b);
                made++;
            end else if (r < 96 && active_window() <= 64) begin
                add_request(OP_RESTART, b);
                made++;
            end else if (r < 98) begin
                add_request(OP_UNUSED, b);
            end else begin
                add_request(OP_DATA, b);
                made++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET: set_target = i_cfg_data[31:0];
                    CFG_MIN:    set_min = i_cfg_data[24:0];
                    CFG_MAX:    set_max = i_cfg_data[24:0];
                    CFG_WLEN:   set_wlen = i_cfg_data[10:0];
                    CFG_HMOD:   set_hmod = i_cfg_data[55:0];
                    default: ;
                endcase
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (pending_writes.size() != 0) begin
                    {i_cfg_index, i_cfg_data} <= pending_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_boundary(i_in_item);
                requests_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if ($urandom_range(0, 99) < send_pct) begin
                    send_gap = $urandom_range(1, BURST_MAX) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_item <= pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_boundaries.size() == 0) begin
                    if (failures < REPORT_MAX) begin
                        $display("%0t: boundary with none expected, end_offset %0d chunk_length %0d",
                                 $time, o_out_item.end_offset, o_out_item.chunk_length);
                    end
                    failures++;
                end else begin
                    due = expected_boundaries.pop_front();
                    boundaries_checked++;
                    if (o_out_item.end_offset !== due.end_offset) begin
                        note_mismatch("end_offset", 64'(due.end_offset),
                                      64'(o_out_item.end_offset));
                    end
                    if (o_out_item.chunk_length !== due.chunk_length) begin
                        note_mismatch("chunk_length", 64'(due.chunk_length),
                                      64'(o_out_item.chunk_length));
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, BURST_MAX) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned ph;
        set_target = RST_TARGET;
        set_min = RST_MIN;
        set_max = RST_MAX;
        set_wlen = RST_WLEN;
        set_hmod = DEFAULT_MOD;
        restart_stream();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: both byte extremes, an ignored request, then one end of stream
        // that closes the open chunk and one that finds it empty.
        add_request(OP_DATA, 8'h00);
        add_request(OP_DATA, 8'hFF);
        add_request(OP_UNUSED, 8'hAA);
        add_request(OP_EOS, 8'h55);
        add_request(OP_EOS, 8'h00);
        add_request(OP_RESTART, 8'hFF);
        drain();

        // Every register zero: default modulus, single-byte window, and each byte closes.
        write_all('0, '0, '0, '0, '0);
        add_request(OP_RESTART, 8'h00);
        add_request(OP_DATA, 8'hFF);
        add_request(OP_DATA, 8'h00);
        add_request(OP_DATA, 8'h5A);
        add_request(OP_EOS, 8'hFF);
        drain();

        // Largest modulus and target, saturated window, and a maximum below the minimum.
        write_all(32'hFFFF_FFFF, 25'd3, 25'd2, 11'd2047, {56{1'b1}});
        add_request(OP_RESTART, 8'h00);
        add_request(OP_DATA, 8'hC3);
        add_request(OP_DATA, 8'h3C);
        add_request(OP_DATA, 8'hFF);
        add_request(OP_DATA, 8'h01);
        add_request(OP_EOS, 8'h00);
        drain();

        // Window and modulus change with no restart, so the held hash and offset carry over.
        write_all(32'd1, 25'd1, 25'd16777216, 11'd5, 56'd2);
        add_request(OP_DATA, 8'h81);
        add_request(OP_DATA, 8'h7E);
        add_request(OP_DATA, 8'hFF);
        add_request(OP_DATA, 8'h00);
        add_request(OP_DATA, 8'h42);
        add_request(OP_DATA, 8'hBD);
        add_request(OP_EOS, 8'h00);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_settings();
            if (ph == RANDOM_PHASES - 1) begin
                send_pct = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: send_pct = 0;
                    1: send_pct = 10;
                    2: send_pct = 40;
                    default: send_pct = 70;
                endcase
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 40;
                    default: stall_pct = 70;
                endcase
            end
            random_traffic(ITEMS_PER_PHASE);
            drain();
        end

        $display("Sent %0d requests under %0d register settings; %0d chunk boundaries compared.",
                 requests_sent, phases_run, boundaries_checked);
        $display("Failures seen: %0d.", failures);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d chunk boundaries still expected.",
                 expected_boundaries.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- content_defined_chunker.f -----
+incdir+src
src/cdc_pkg.sv
src/cdc_ram.sv
src/content_defined_chunker.sv
bench/content_defined_chunker_tb.sv
